FILE: hw/rtl/gauss_seidel_solver_assert.svh
// assertion macros for the gauss-seidel solver checker
// all macros sample on aclk; the same-cycle and next-cycle forms hold off while aresetn is low
`ifndef GAUSS_SEIDEL_SOLVER_ASSERT_SVH
`define GAUSS_SEIDEL_SOLVER_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define GSOLV_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("gsolv check failed");

// antecedent implies consequent in the next cycle
`define GSOLV_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("gsolv check failed");

// no reset masking, for checks on reset itself
`define GSOLV_ASSERT_RAW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error("gsolv check failed");

`endif

FILE: hw/rtl/gsolv_pkg.sv
// ----------------------------------------------------------------------------
// gsolv_pkg
// shared field widths and codes of the gauss-seidel solver
// ----------------------------------------------------------------------------
package gsolv_pkg;

    localparam int ACT_W   = 2;
    localparam int IDX_W   = 4;
    localparam int VAL_W   = 32;
    localparam int DIM_W   = 5;
    localparam int SWP_W   = 16;
    localparam int S_DATA_W = 40;   // row, col, value
    localparam int M_DATA_W = 40;   // index, solution, zero pad

    // request kinds
    localparam logic [ACT_W-1:0] ACT_MATRIX = 2'd0;
    localparam logic [ACT_W-1:0] ACT_RHS    = 2'd1;
    localparam logic [ACT_W-1:0] ACT_SOLVE  = 2'd2;

    // configuration register indexes
    localparam logic REG_DIMENSION = 1'b0;
    localparam logic REG_SWEEPS    = 1'b1;

    // result status
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_DIAG = 1'b1;

endpackage

FILE: hw/rtl/gauss_seidel_solver.sv
// sequence: a solve checks each diagonal and forms its reciprocal, then runs the sweeps,
// then sends one result per solution element in index order
// throughput: load requests one per cycle while idle; one solve at a time, set by the shared
// 32x32 multiplier and the bit-serial reciprocal divider
// reset: synchronous active-low aresetn clears control state, dimension 16, sweeps 8
// ----------------------------------------------------------------------------
// gauss_seidel_solver
// solves A*x=b in signed fixed point by Gauss-Seidel sweeps over stored A and b
// ----------------------------------------------------------------------------
module gauss_seidel_solver #(
    parameter int MAX_DIM   = 16,
    parameter int FRAC_BITS = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // request channel
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [gsolv_pkg::S_DATA_W-1:0]  s_tdata,   // row[3:0], col[7:4], value[39:8]
    input  logic [gsolv_pkg::ACT_W-1:0]     s_tuser,   // action[1:0]
    // result channel
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [gsolv_pkg::M_DATA_W-1:0]  m_tdata,   // index[3:0], solution[35:4], zero
    output logic                            m_tuser,   // status[0]
    output logic                            m_tlast,
    // configuration write channel
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic                            cfg_index,
    input  logic [gsolv_pkg::SWP_W-1:0]     cfg_data
);
    import gsolv_pkg::*;

    localparam int IW  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int AW  = 2 * IW;
    localparam int QW  = 2 * FRAC_BITS + 1;
    localparam int CW  = $clog2(QW + 1);
    localparam logic [VAL_W-1:0] ONE    = VAL_W'(1) << FRAC_BITS;
    localparam logic [VAL_W-1:0] SATMAX = 32'h7FFF_FFFF;

    typedef enum logic [3:0] {
        ST_IDLE, ST_DIAG_RD, ST_DIAG_CHK, ST_DIV, ST_DIV_WB,
        ST_ROW_RD, ST_ROW_INIT, ST_TERM_RD, ST_TERM_MUL, ST_TERM_ACC,
        ST_FIN_MUL, ST_FIN_WB, ST_OUT_RD, ST_OUT_SEND, ST_ERR
    } state_t;

    // fixed-point product: floor shift then saturate
    function automatic logic [VAL_W-1:0] fx_scale(input logic signed [63:0] p);
        logic signed [63:0] q;
        q = p >>> FRAC_BITS;
        if (q > 64'sh0000_0000_7FFF_FFFF) return SATMAX;
        if (q < -64'sh0000_0000_8000_0000) return 32'h8000_0000;
        return q[VAL_W-1:0];
    endfunction

    // saturating subtract
    function automatic logic [VAL_W-1:0] fx_sub(input logic [VAL_W-1:0] a,
                                                input logic [VAL_W-1:0] b);
        logic [VAL_W:0] d;
        d = {a[VAL_W-1], a} - {b[VAL_W-1], b};
        if (d[VAL_W] != d[VAL_W-1]) return d[VAL_W] ? 32'h8000_0000 : SATMAX;
        return d[VAL_W-1:0];
    endfunction

    // unpacked request fields
    logic [ACT_W-1:0] act;
    logic [7:0]       row_ext, col_ext;
    logic [VAL_W-1:0] in_val;
    logic             s_fire;
    assign act     = s_tuser;
    assign row_ext = {4'b0, s_tdata[3:0]};
    assign col_ext = {4'b0, s_tdata[7:4]};
    assign in_val  = s_tdata[39:8];
    assign s_fire  = s_tvalid && s_tready;

    state_t             state_reg;
    logic [DIM_W-1:0]   dim_reg;
    logic [SWP_W-1:0]   sweeps_reg, s_reg;
    logic [IW-1:0]      nm1_reg, i_reg, k_reg;
    logic [VAL_W-1:0]   d_reg, acc_reg;
    logic [VAL_W:0]     rem_reg;
    logic [QW-1:0]      quo_reg;
    logic [CW-1:0]      cnt_reg;
    logic signed [63:0] prod_reg;
    logic               m_valid_reg, m_last_reg, m_status_reg;
    logic [IDX_W-1:0]   m_index_reg;
    logic [VAL_W-1:0]   m_sol_reg;

    // stores, read data registered
    logic [VAL_W-1:0] mat_mem_reg [1 << AW];
    logic [VAL_W-1:0] rhs_mem_reg [1 << IW];
    logic [VAL_W-1:0] rcp_mem_reg [1 << IW];
    logic [VAL_W-1:0] x_mem_reg   [1 << IW];
    logic [VAL_W-1:0] mat_q_reg, rhs_q_reg, rcp_q_reg, x_q_reg;

    logic             mat_we, rhs_we, rcp_we, x_we;
    logic [AW-1:0]    mat_waddr, mat_raddr;
    logic [IW-1:0]    x_waddr, x_raddr, row_idx;
    logic [VAL_W-1:0] x_wdata, rcp_wdata;

    assign row_idx   = row_ext[IW-1:0];
    assign mat_waddr = {row_idx, col_ext[IW-1:0]};
    assign mat_we    = s_fire && act == ACT_MATRIX && 32'(row_ext) < MAX_DIM
                       && 32'(col_ext) < MAX_DIM;
    assign rhs_we    = s_fire && act == ACT_RHS && 32'(row_ext) < MAX_DIM;
    assign rcp_we    = state_reg == ST_DIV_WB;
    assign rcp_wdata = (quo_reg > QW'(SATMAX)) ? SATMAX : VAL_W'(quo_reg);

    // read and write addresses per sequencer step
    always_comb begin
        mat_raddr = {i_reg, k_reg};
        x_raddr   = k_reg;
        x_we      = 1'b0;
        x_waddr   = i_reg;
        x_wdata   = fx_scale(prod_reg);
        unique case (state_reg)
            ST_DIAG_RD: begin
                mat_raddr = {i_reg, i_reg};
                x_we      = 1'b1;
                x_wdata   = (i_reg == '0) ? ONE : '0;
            end
            ST_FIN_WB: x_we = 1'b1;
            ST_OUT_RD, ST_OUT_SEND: x_raddr = i_reg;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mat_we) mat_mem_reg[mat_waddr] <= in_val;
        mat_q_reg <= mat_mem_reg[mat_raddr];
    end

    always_ff @(posedge aclk) begin
        if (rhs_we) rhs_mem_reg[row_idx] <= in_val;
        rhs_q_reg <= rhs_mem_reg[i_reg];
    end

    always_ff @(posedge aclk) begin
        if (rcp_we) rcp_mem_reg[i_reg] <= rcp_wdata;
        rcp_q_reg <= rcp_mem_reg[i_reg];
    end

    always_ff @(posedge aclk) begin
        if (x_we) x_mem_reg[x_waddr] <= x_wdata;
        x_q_reg <= x_mem_reg[x_raddr];
    end

    // divider step: next dividend bit is one only on the first step
    logic [VAL_W:0] rem_sh;
    logic           q_bit;
    assign rem_sh = {rem_reg[VAL_W-1:0], (cnt_reg == '0)};
    assign q_bit  = rem_sh >= {1'b0, d_reg};

    // result register loads when a result is ready and the slot is free
    logic m_load;
    assign m_load = (state_reg == ST_OUT_SEND || state_reg == ST_ERR)
                    && (!m_valid_reg || m_tready);

    // sequencer and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            dim_reg     <= DIM_W'(16);
            sweeps_reg  <= SWP_W'(8);
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                if (cfg_index == REG_DIMENSION) dim_reg <= cfg_data[DIM_W-1:0];
                else sweeps_reg <= cfg_data;
            end
            if (m_load) m_valid_reg <= 1'b1;
            else if (m_tready) m_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE: begin
                    if (s_fire && act == ACT_SOLVE) begin
                        if (dim_reg == '0) nm1_reg <= '0;
                        else if (32'(dim_reg) > MAX_DIM) nm1_reg <= IW'(MAX_DIM - 1);
                        else nm1_reg <= IW'(dim_reg - 1'b1);
                        i_reg     <= '0;
                        state_reg <= ST_DIAG_RD;
                    end
                end
                ST_DIAG_RD: state_reg <= ST_DIAG_CHK;
                ST_DIAG_CHK: begin
                    if (mat_q_reg[VAL_W-1] || mat_q_reg == '0) begin
                        state_reg <= ST_ERR;
                    end else begin
                        d_reg     <= mat_q_reg;
                        rem_reg   <= '0;
                        quo_reg   <= '0;
                        cnt_reg   <= '0;
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    rem_reg <= q_bit ? rem_sh - {1'b0, d_reg} : rem_sh;
                    quo_reg <= {quo_reg[QW-2:0], q_bit};
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CW'(QW - 1)) state_reg <= ST_DIV_WB;
                end
                ST_DIV_WB: begin
                    if (i_reg == nm1_reg) begin
                        i_reg     <= '0;
                        s_reg     <= '0;
                        state_reg <= (sweeps_reg == '0) ? ST_OUT_RD : ST_ROW_RD;
                    end else begin
                        i_reg     <= i_reg + 1'b1;
                        state_reg <= ST_DIAG_RD;
                    end
                end
                // one row: acc = b[j] - sum over k != j of A[j][k]*x[k], x[j] = acc * recip[j]
                ST_ROW_RD: begin
                    k_reg     <= '0;
                    state_reg <= ST_ROW_INIT;
                end
                ST_ROW_INIT: begin
                    acc_reg   <= rhs_q_reg;
                    state_reg <= ST_TERM_RD;
                end
                ST_TERM_RD: begin
                    if (k_reg != i_reg) state_reg <= ST_TERM_MUL;
                    else if (k_reg == nm1_reg) state_reg <= ST_FIN_MUL;
                    else k_reg <= k_reg + 1'b1;
                end
                ST_TERM_MUL: begin
                    prod_reg  <= signed'(mat_q_reg) * signed'(x_q_reg);
                    state_reg <= ST_TERM_ACC;
                end
                ST_TERM_ACC: begin
                    acc_reg <= fx_sub(acc_reg, fx_scale(prod_reg));
                    if (k_reg == nm1_reg) begin
                        state_reg <= ST_FIN_MUL;
                    end else begin
                        k_reg     <= k_reg + 1'b1;
                        state_reg <= ST_TERM_RD;
                    end
                end
                ST_FIN_MUL: begin
                    prod_reg  <= signed'(acc_reg) * signed'(rcp_q_reg);
                    state_reg <= ST_FIN_WB;
                end
                ST_FIN_WB: begin
                    if (i_reg == nm1_reg) begin
                        i_reg <= '0;
                        s_reg <= s_reg + 1'b1;
                        if ({1'b0, s_reg} + 1'b1 == {1'b0, sweeps_reg})
                            state_reg <= ST_OUT_RD;
                        else
                            state_reg <= ST_ROW_RD;
                    end else begin
                        i_reg     <= i_reg + 1'b1;
                        state_reg <= ST_ROW_RD;
                    end
                end
                ST_OUT_RD: state_reg <= ST_OUT_SEND;
                ST_OUT_SEND: begin
                    if (m_load) begin
                        m_index_reg  <= IDX_W'(i_reg);
                        m_sol_reg    <= x_q_reg;
                        m_status_reg <= STATUS_OK;
                        m_last_reg   <= i_reg == nm1_reg;
                        if (i_reg == nm1_reg) begin
                            state_reg <= ST_IDLE;
                        end else begin
                            i_reg     <= i_reg + 1'b1;
                            state_reg <= ST_OUT_RD;
                        end
                    end
                end
                ST_ERR: begin
                    if (m_load) begin
                        m_index_reg  <= '0;
                        m_sol_reg    <= '0;
                        m_status_reg <= STATUS_DIAG;
                        m_last_reg   <= 1'b1;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_tready  = state_reg == ST_IDLE;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = {4'b0, m_sol_reg, m_index_reg};
    assign m_tuser   = m_status_reg;
    assign m_tlast   = m_last_reg;

endmodule

FILE: hw/rtl/gsolv_checker.sv
// ----------------------------------------------------------------------------
// gsolv_checker
// port-level checks of the gauss-seidel solver, bound to the top level
// ----------------------------------------------------------------------------
`include "gauss_seidel_solver_assert.svh"

module gsolv_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic [gsolv_pkg::ACT_W-1:0]     s_tuser,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [gsolv_pkg::M_DATA_W-1:0]  m_tdata,
    input logic                            m_tuser,
    input logic                            m_tlast
);
    import gsolv_pkg::*;

    // a stalled result holds
    `GSOLV_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    // an error result is a lone zero result that closes the solve
    `GSOLV_ASSERT_SAME(a_err, m_tvalid && m_tuser == STATUS_DIAG, m_tlast && m_tdata == '0)
    // a solve request makes the block busy
    `GSOLV_ASSERT_NEXT(a_busy, s_tvalid && s_tready && s_tuser == ACT_SOLVE, !s_tready)
    // reset empties the result register
    `GSOLV_ASSERT_RAW(a_rst, !aresetn, !m_tvalid)

endmodule

bind gauss_seidel_solver gsolv_checker u_gsolv_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

FILE: tb/gauss_seidel_solver_tb.sv
// ----------------------------------------------------------------------------
// gauss_seidel_solver_tb
// Loads matrix and rhs entries into the solver and starts solves. Each accepted
// request goes through a fixed-point Gauss-Seidel predictor. Every result is
// compared in order against the predicted solution elements or the error
// result. The run covers several dimension and sweep settings and several
// patterns of idle cycles on the request and result sides.
// ----------------------------------------------------------------------------
module gauss_seidel_solver_tb;
    import gsolv_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int               NDIM       = 16;
    localparam int               QBITS      = 16;
    localparam int               WDOG_LIMIT = 2000000;
    localparam logic [ACT_W-1:0] ACT_NONE   = 2'd3;

    typedef struct {
        logic [ACT_W-1:0]  act;
        logic [IDX_W-1:0]  row;
        logic [IDX_W-1:0]  col;
        logic [VAL_W-1:0]  val;
    } req_t;

    typedef struct {
        logic [IDX_W-1:0]  index;
        logic [VAL_W-1:0]  solution;
        logic              status;
        logic              last;
    } res_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_DATA_W-1:0]    s_tdata = '0;
    logic [ACT_W-1:0]       s_tuser = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_DATA_W-1:0]    m_tdata;
    logic                   m_tuser;
    logic                   m_tlast;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic                   cfg_index = REG_DIMENSION;
    logic [SWP_W-1:0]       cfg_data = '0;

    gauss_seidel_solver dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    req_t   pending_reqs[$];
    res_t   solution_q[$];
    int     send_idle_pct = 0;
    int     recv_stall_pct = 0;
    int     mismatches = 0;
    int     items_made = 0;

    // predictor state
    logic signed [31:0] a_mat [NDIM*NDIM];
    logic signed [31:0] b_vec [NDIM];
    logic signed [31:0] inv_diag [NDIM];
    logic signed [31:0] x_vec [NDIM];
    logic [DIM_W-1:0]   dim_reg = 5'd16;
    logic [SWP_W-1:0]   sweep_reg = 16'd8;

    // stimulus bookkeeping: which entries have been loaded
    bit                 a_loaded [NDIM][NDIM];
    bit                 b_loaded [NDIM];
    logic [DIM_W-1:0]   gen_dim = 5'd16;

    function automatic int eff_dim(logic [DIM_W-1:0] d);
        if (d == 0) return 1;
        if (d > NDIM) return NDIM;
        return int'(d);
    endfunction

    function automatic logic signed [31:0] sat32(longint v);
        if (v > longint'(32'sh7fffffff)) return 32'sh7fffffff;
        if (v < -longint'(64'sh80000000)) return 32'sh80000000;
        return v[31:0];
    endfunction

    // truncating product, floor toward minus infinity
    function automatic logic signed [31:0] qmul(logic signed [31:0] a, logic signed [31:0] b);
        longint p;
        p = longint'(a) * longint'(b);
        return sat32(p >>> QBITS);
    endfunction

    function automatic logic signed [31:0] qsub(logic signed [31:0] a, logic signed [31:0] b);
        return sat32(longint'(a) - longint'(b));
    endfunction

    function automatic logic signed [31:0] qrecip(logic signed [31:0] d);
        longint q;
        q = (64'sd1 << (2 * QBITS)) / longint'(d);
        return sat32(q);
    endfunction

    // updates the solver model with one accepted request, queues its results
    function automatic void solve_model(req_t r);
        int   n;
        res_t e;
        logic signed [31:0] acc;
        if (r.act == ACT_MATRIX) begin
            a_mat[r.row * NDIM + r.col] = r.val;
            return;
        end
        if (r.act == ACT_RHS) begin
            b_vec[r.row] = r.val;
            return;
        end
        if (r.act != ACT_SOLVE) return;
        n = eff_dim(dim_reg);
        for (int i = 0; i < n; i++) x_vec[i] = 0;
        x_vec[0] = 32'sd1 << QBITS;
        for (int i = 0; i < n; i++) begin
            if (a_mat[i * NDIM + i] <= 0) begin
                e = '{index: 0, solution: 0, status: STATUS_DIAG, last: 1'b1};
                solution_q.push_back(e);
                return;
            end
            inv_diag[i] = qrecip(a_mat[i * NDIM + i]);
        end
        for (int s = 0; s < int'(sweep_reg); s++) begin
            for (int j = 0; j < n; j++) begin
                acc = b_vec[j];
                for (int k = 0; k < n; k++) begin
                    if (k != j) acc = qsub(acc, qmul(a_mat[j * NDIM + k], x_vec[k]));
                end
                x_vec[j] = qmul(acc, inv_diag[j]);
            end
        end
        for (int i = 0; i < n; i++) begin
            e = '{index: i[3:0], solution: x_vec[i], status: STATUS_OK, last: (i == n - 1)};
            solution_q.push_back(e);
        end
    endfunction

    // request driver
    always @(posedge aclk) begin
        req_t r;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                r.act = s_tuser;
                r.row = s_tdata[3:0];
                r.col = s_tdata[7:4];
                r.val = s_tdata[39:8];
                solve_model(r);
            end
            if (!s_tvalid || s_tready) begin
                if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    r = pending_reqs.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= r.act;
                    s_tdata  <= {r.val, r.col, r.row};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge aclk) begin
        res_t e;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
            if (m_tvalid && m_tready) begin
                if (solution_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: index %0d solution %h status %0d last %0d",
                                 m_tdata[3:0], m_tdata[35:4], m_tuser, m_tlast);
                end else begin
                    e = solution_q.pop_front();
                    if (m_tdata[3:0] !== e.index || m_tdata[35:4] !== e.solution ||
                        m_tuser !== e.status || m_tlast !== e.last) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch: exp idx %0d sol %h st %0d last %0d, ",
                                      "got %0d %h %0d %0d"},
                                     e.index, e.solution, e.status, e.last,
                                     m_tdata[3:0], m_tdata[35:4], m_tuser, m_tlast);
                    end
                end
            end
        end
    end

    // watchdog on cycles with no handshake at all
    always @(posedge aclk) begin
        int quiet;
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            quiet = 0;
        end else begin
            quiet++;
            if (quiet >= WDOG_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    function automatic void push_req(logic [ACT_W-1:0] act, int row, int col,
                                     logic [31:0] val);
        req_t r;
        r = '{act: act, row: row[3:0], col: col[3:0], val: val};
        pending_reqs.push_back(r);
        items_made++;
        if (act == ACT_MATRIX) a_loaded[row][col] = 1'b1;
        if (act == ACT_RHS) b_loaded[row] = 1'b1;
    endfunction

    // diagonals positive and dominant-ish, off-diagonals small signed
    function automatic logic [31:0] entry_val(int row, int col);
        if (row == col) return $urandom_range(32'h8000, 32'h40000);
        return $urandom_range(32'h4000) - 32'h2000;
    endfunction

    // loads every in-use entry not yet written so a solve never reads garbage
    function automatic void fill_unloaded();
        int n;
        n = eff_dim(gen_dim);
        for (int r = 0; r < n; r++) begin
            for (int c = 0; c < n; c++)
                if (!a_loaded[r][c]) push_req(ACT_MATRIX, r, c, entry_val(r, c));
            if (!b_loaded[r]) push_req(ACT_RHS, r, 0, $urandom);
        end
    endfunction

    function automatic void push_solve();
        fill_unloaded();
        push_req(ACT_SOLVE, $urandom_range(15), $urandom_range(15), $urandom);
    endfunction

    // random requests, mostly well-formed loads followed by solves
    function automatic void random_reqs(int count);
        int n, sel, r, c;
        for (int i = 0; i < count; i++) begin
            n = eff_dim(gen_dim);
            sel = $urandom_range(99);
            r = $urandom_range(n - 1);
            c = $urandom_range(n - 1);
            if (sel < 50) push_req(ACT_MATRIX, r, c, entry_val(r, c));
            else if (sel < 70) push_req(ACT_RHS, r, $urandom_range(15), $urandom);
            else if (sel < 82) push_solve();
            else if (sel < 90) push_req(ACT_MATRIX, $urandom_range(15), $urandom_range(15),
                                        $urandom);
            else if (sel < 94) push_req(ACT_NONE, $urandom_range(15), $urandom_range(15),
                                        $urandom);
            else begin
                // non-positive diagonal then a solve
                push_req(ACT_MATRIX, r, r, (sel[0]) ? 32'd0 : -$urandom_range(1, 32'h7fffffff));
                push_solve();
                push_req(ACT_MATRIX, r, r, entry_val(r, r));
            end
        end
    endfunction

    task automatic wait_idle();
        do @(posedge aclk);
        while (pending_reqs.size() > 0 || s_tvalid || solution_q.size() > 0);
        repeat (30) @(posedge aclk);
    endtask

    task automatic write_reg(logic idx, logic [SWP_W-1:0] data);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_DIMENSION) dim_reg = data[DIM_W-1:0];
        else sweep_reg = data;
    endtask

    task automatic new_phase(logic [DIM_W-1:0] d, logic [SWP_W-1:0] sw, int tx, int rx);
        wait_idle();
        write_reg(REG_DIMENSION, 16'(d));
        write_reg(REG_SWEEPS, sw);
        gen_dim = d;
        send_idle_pct = tx;
        recv_stall_pct = rx;
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: 3x3 system with extreme off-diagonal and diagonal values
        new_phase(5'd3, 16'd2, 0, 0);
        push_req(ACT_MATRIX, 0, 0, 32'h0001_0000);
        push_req(ACT_MATRIX, 0, 1, 32'h7fff_ffff);
        push_req(ACT_MATRIX, 0, 2, 32'h8000_0000);
        push_req(ACT_MATRIX, 1, 0, 32'h0000_8000);
        push_req(ACT_MATRIX, 1, 1, 32'h0000_0001);
        push_req(ACT_MATRIX, 1, 2, 32'hffff_0000);
        push_req(ACT_MATRIX, 2, 0, 32'h0000_0000);
        push_req(ACT_MATRIX, 2, 1, 32'h0000_4000);
        push_req(ACT_MATRIX, 2, 2, 32'h7fff_ffff);
        push_req(ACT_RHS, 0, 15, 32'h7fff_ffff);
        push_req(ACT_RHS, 1, 0, 32'h8000_0000);
        push_req(ACT_RHS, 2, 0, 32'h0003_0000);
        push_req(ACT_MATRIX, 15, 15, 32'h8000_0000);
        push_req(ACT_RHS, 15, 0, 32'h7fff_ffff);
        push_req(ACT_NONE, 15, 15, 32'hffff_ffff);
        push_req(ACT_SOLVE, 0, 0, 32'h0);
        push_req(ACT_MATRIX, 1, 1, 32'h0);
        push_req(ACT_SOLVE, 0, 0, 32'h0);
        push_req(ACT_MATRIX, 1, 1, 32'h8000_0000);
        push_req(ACT_SOLVE, 0, 0, 32'h0);
        push_req(ACT_MATRIX, 1, 1, 32'h0002_0000);
        push_req(ACT_SOLVE, 0, 0, 32'h0);

        // dimension zero acts as one, largest sweep count
        new_phase(5'd0, 16'hffff, 56, 0);
        random_reqs(12);
        push_solve();

        new_phase(5'd4, 16'd5, 0, 56);
        random_reqs(90);

        // dimension above the maximum acts as the maximum
        new_phase(5'd31, 16'd1, 37, 37);
        random_reqs(15);
        push_solve();

        new_phase(5'd16, 16'd0, 0, 0);
        random_reqs(25);

        new_phase(5'd2, 16'd12, 56, 0);
        random_reqs(40);

        while (items_made < 450) begin
            new_phase($urandom_range(1, 8), $urandom_range(1, 10),
                      ($urandom_range(1)) ? 37 : 0, ($urandom_range(1)) ? 37 : 56);
            random_reqs(40);
        end

        wait_idle();
        repeat (100) @(posedge aclk);
        if (mismatches == 0 && solution_q.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/gsolv_pkg.sv
hw/rtl/gauss_seidel_solver.sv
hw/rtl/gsolv_checker.sv
tb/gauss_seidel_solver_tb.sv
